// ===== rtl/hmn_pkg.sv =====
// Shared types and constants for the histogram min-max normalizer.
// Holds operation codes, the queued command format, back-end states and status.
// No dependencies; every other file refers to it by scoped names.
package hmn_pkg;

  localparam int OP_W        = 2;
  localparam int PIX_W       = 8;
  localparam int HEIGHT_W    = 8;
  localparam int SCALE_W     = 8;
  localparam int QUOT_STEPS  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_TOP_RESET = 8'd230;

  // Commands after classification. A read of a bin past the end of the
  // histogram needs no scan and answers with height zero.
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PIX_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_LAST,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/hmn_if.sv =====
// Valid/ready channel interfaces for the histogram normalizer input and result words.
// Depends on hmn_pkg for field widths.
interface hmn_in_if;
  logic                        valid;
  logic                        ready;
  logic [hmn_pkg::OP_W-1:0]    operation;
  logic [hmn_pkg::PIX_W-1:0]   pixel;
  logic [hmn_pkg::PIX_W-1:0]   bin_index;

  modport source (output valid, operation, pixel, bin_index, input ready);
  modport sink   (input valid, operation, pixel, bin_index, output ready);
endinterface

interface hmn_out_if;
  logic                         valid;
  logic                         ready;
  logic [hmn_pkg::PIX_W-1:0]    bin_index_out;
  logic [hmn_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, bin_index_out, height, input ready);
  modport sink   (input valid, bin_index_out, height, output ready);
endinterface

// ===== rtl/histogram_minmax_normalize.sv =====
// Top level of the grey-level histogram with min-max normalized readout.
// Depends on hmn_pkg, hmn_if, hmn_front, hmn_fifo and hmn_back.

// The block keeps BINS saturating counters of COUNT_BITS bits in a single-port-write,
// registered-read memory and handles three kinds of input word: clear, add pixel and
// read height. A front end classifies each word and places it in a four-entry command
// queue; a back end drains the queue against the bin memory. Adds stream at one word
// per cycle while the back end is idle: each passes through a read-increment-write
// pipeline, and a forwarding register covers back-to-back adds to the same bin. A clear
// sweeps the memory one bin per cycle. A read scans every bin for minimum and maximum,
// forms (count - min) * scale_top in a multiply state, and runs an eight-step
// restoring divider; a read of a bin past the end needs no scan and returns height 0.
// After reset the block zeroes the memory in a clearing pass during which in_ch.ready
// stays low. The result word sits in an output register, so the front keeps taking
// words while a result waits. scale_top must be written through cfg_we/cfg_wdata only
// while idle; the user is bound to this, and the block itself does not enforce it.
module histogram_minmax_normalize #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hmn_in_if.sink                      in_ch,
  hmn_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [hmn_pkg::SCALE_W-1:0] cfg_wdata
);

  logic [hmn_pkg::SCALE_W-1:0] scale_top_r;

  hmn_pkg::back_status_t status;
  hmn_pkg::cmd_t         push_cmd;
  hmn_pkg::cmd_t         head;
  logic                  push;
  logic                  pop;
  logic                  fifo_empty;
  logic                  fifo_full;

  // The only configuration register: the height given to the fullest bin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_top_r <= hmn_pkg::SCALE_TOP_RESET;
    end else if (cfg_we) begin
      scale_top_r <= cfg_wdata;
    end
  end

  // Classification drops unused operation codes and out-of-range pixels.
  hmn_front #(
    .BINS (BINS)
  ) u_front (
    .in_ch     (in_ch),
    .status    (status),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  hmn_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  hmn_back #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_top (scale_top_r),
    .head      (head),
    .empty     (fifo_empty),
    .pop       (pop),
    .status    (status),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/hmn_front.sv =====
// Front end: accepts input words and turns them into queued commands.
// Depends on hmn_pkg and hmn_in_if.
module hmn_front #(
  parameter int BINS = 256
) (
  hmn_in_if.sink               in_ch,
  input  hmn_pkg::back_status_t status,
  input  logic                 fifo_full,
  output logic                 push,
  output hmn_pkg::cmd_t        push_cmd
);

  logic take;

  assign in_ch.ready = !fifo_full && !status.init_busy;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    push          = 1'b0;
    push_cmd.kind = hmn_pkg::CMD_ADD;
    push_cmd.addr = in_ch.pixel;
    case (in_ch.operation)
      hmn_pkg::OP_CLEAR: begin
        push          = take;
        push_cmd.kind = hmn_pkg::CMD_CLEAR;
      end
      hmn_pkg::OP_ADD: begin
        // Pixels past the last bin are dropped here.
        push          = take && (int'(in_ch.pixel) < BINS);
        push_cmd.kind = hmn_pkg::CMD_ADD;
      end
      hmn_pkg::OP_READ: begin
        push          = take;
        push_cmd.addr = in_ch.bin_index;
        push_cmd.kind = (int'(in_ch.bin_index) < BINS) ? hmn_pkg::CMD_READ
                                                       : hmn_pkg::CMD_READ_NONE;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/hmn_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on hmn_pkg for the command type and the queue depth.
module hmn_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hmn_pkg::cmd_t push_cmd,
  input  logic          pop,
  output hmn_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int DEPTH = hmn_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  hmn_pkg::cmd_t    q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == FULL_CNT);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/hmn_back.sv =====
// Back end: bin memory, add pipeline, clear sweep, min/max scan, divider, result register.
// Depends on hmn_pkg and hmn_out_if.
module hmn_back #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hmn_pkg::SCALE_W-1:0]   scale_top,
  input  hmn_pkg::cmd_t                 head,
  input  logic                          empty,
  output logic                          pop,
  output hmn_pkg::back_status_t         status,
  hmn_out_if.source                     out_ch
);

  localparam int IDX_W  = $clog2(BINS);
  localparam int NUM_W  = COUNT_BITS + hmn_pkg::SCALE_W;
  localparam int STEP_W = $clog2(hmn_pkg::QUOT_STEPS);
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(BINS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rdata_r;

  hmn_pkg::back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic                  init_r;

  logic                  add_vld_r;
  logic [IDX_W-1:0]      add_addr_r;
  logic                  fwd_vld_r;
  logic [IDX_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] add_old;
  logic [COUNT_BITS-1:0] add_new;

  logic                  scan_vld_r;
  logic [IDX_W-1:0]      scan_addr_r;
  logic [IDX_W-1:0]      tgt_r;
  logic [hmn_pkg::PIX_W-1:0] idx_r;
  logic [COUNT_BITS-1:0] lo_r, hi_r, cnt_r;
  logic [NUM_W-1:0]      num_r;
  logic [NUM_W-1:0]      trial;
  logic [COUNT_BITS-1:0] den_r;
  logic                  flat_r;
  logic [hmn_pkg::HEIGHT_W-1:0] quo_r;
  logic [STEP_W-1:0]     step_r;

  logic                  out_vld_r;
  logic [hmn_pkg::PIX_W-1:0]    out_idx_r;
  logic [hmn_pkg::HEIGHT_W-1:0] out_height_r;
  logic                  out_free;

  logic                  mem_re, mem_we;
  logic [IDX_W-1:0]      mem_raddr, mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  start_add, start_read, load_out, out_from_read;

  assign out_free       = !out_vld_r || out_ch.ready;
  assign status.init_busy = init_r;

  // The read issued in the previous cycle misses the write made in that cycle.
  assign add_old = (fwd_vld_r && (fwd_addr_r == add_addr_r)) ? fwd_data_r : rdata_r;
  assign add_new = (add_old == CNT_MAX) ? add_old : add_old + 1'b1;
  assign trial   = NUM_W'(den_r) << step_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hmn_pkg::ST_IDLE: begin
        if (!empty && !add_vld_r) begin
          if (head.kind == hmn_pkg::CMD_CLEAR) begin
            state_nxt = hmn_pkg::ST_CLEAR;
          end else if (head.kind == hmn_pkg::CMD_READ) begin
            state_nxt = hmn_pkg::ST_SCAN;
          end
        end
      end
      hmn_pkg::ST_CLEAR: if (ptr_r == LAST_IDX) state_nxt = hmn_pkg::ST_IDLE;
      hmn_pkg::ST_SCAN:  if (ptr_r == LAST_IDX) state_nxt = hmn_pkg::ST_LAST;
      hmn_pkg::ST_LAST:  state_nxt = hmn_pkg::ST_MUL;
      hmn_pkg::ST_MUL:   state_nxt = hmn_pkg::ST_DIV;
      hmn_pkg::ST_DIV:   if (step_r == '0) state_nxt = hmn_pkg::ST_DONE;
      hmn_pkg::ST_DONE:  if (out_free) state_nxt = hmn_pkg::ST_IDLE;
      default:           state_nxt = hmn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;
    mem_we        = add_vld_r;
    mem_waddr     = add_addr_r;
    mem_wdata     = add_new;
    start_add     = 1'b0;
    start_read    = 1'b0;
    load_out      = 1'b0;
    out_from_read = 1'b0;
    case (state_r)
      hmn_pkg::ST_IDLE: begin
        if (!empty) begin
          case (head.kind)
            hmn_pkg::CMD_ADD: begin
              pop       = 1'b1;
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(head.addr);
              start_add = 1'b1;
            end
            hmn_pkg::CMD_CLEAR: pop = !add_vld_r;
            hmn_pkg::CMD_READ: begin
              pop        = !add_vld_r;
              start_read = !add_vld_r;
            end
            hmn_pkg::CMD_READ_NONE: begin
              pop      = out_free;
              load_out = out_free;
            end
            default: pop = 1'b0;
          endcase
        end
      end
      hmn_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
      end
      hmn_pkg::ST_SCAN: begin
        mem_re = 1'b1;
      end
      hmn_pkg::ST_DONE: begin
        load_out      = out_free;
        out_from_read = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    ptr_nxt = '0;
    if ((state_r == hmn_pkg::ST_CLEAR) || (state_r == hmn_pkg::ST_SCAN)) begin
      ptr_nxt = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hmn_pkg::ST_CLEAR;
      ptr_r      <= '0;
      init_r     <= 1'b1;
      add_vld_r  <= 1'b0;
      fwd_vld_r  <= 1'b0;
      scan_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      if ((state_r == hmn_pkg::ST_CLEAR) && (ptr_r == LAST_IDX)) begin
        init_r <= 1'b0;
      end
      add_vld_r  <= start_add;
      fwd_vld_r  <= add_vld_r;
      scan_vld_r <= (state_r == hmn_pkg::ST_SCAN);
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_add) begin
      add_addr_r <= IDX_W'(head.addr);
    end
    fwd_addr_r  <= add_addr_r;
    fwd_data_r  <= add_new;
    scan_addr_r <= ptr_r;
    if (start_read) begin
      tgt_r <= IDX_W'(head.addr);
      idx_r <= head.addr;
    end
    if (scan_vld_r) begin
      if (scan_addr_r == '0) begin
        lo_r <= rdata_r;
        hi_r <= rdata_r;
      end else begin
        if (rdata_r < lo_r) lo_r <= rdata_r;
        if (rdata_r > hi_r) hi_r <= rdata_r;
      end
      if (scan_addr_r == tgt_r) begin
        cnt_r <= rdata_r;
      end
    end
    if (state_r == hmn_pkg::ST_MUL) begin
      num_r  <= NUM_W'(cnt_r - lo_r) * NUM_W'(scale_top);
      den_r  <= hi_r - lo_r;
      flat_r <= (hi_r == lo_r);
      quo_r  <= '0;
      step_r <= STEP_W'(hmn_pkg::QUOT_STEPS - 1);
    end
    if (state_r == hmn_pkg::ST_DIV) begin
      // Restoring division; the quotient never exceeds scale_top.
      if (num_r >= trial) begin
        num_r         <= num_r - trial;
        quo_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
    if (load_out) begin
      out_idx_r    <= out_from_read ? idx_r : head.addr;
      out_height_r <= (out_from_read && !flat_r) ? quo_r : '0;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.bin_index_out = out_idx_r;
  assign out_ch.height        = out_height_r;

endmodule
